@@ hdl/triangle_edge_dedup_table_defines.svh @@
// Assertion macros shared by the edge table design.
`ifndef TRIANGLE_EDGE_DEDUP_TABLE_DEFINES_SVH
`define TRIANGLE_EDGE_DEDUP_TABLE_DEFINES_SVH

// A condition that holds at every clock edge out of reset.
`define TEDT_ASSERT_ALWAYS(label, clk, rstn, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (cond)) else $error(msg);

// A condition that implies another one in the same cycle.
`define TEDT_ASSERT_IMPLIES(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// A condition that implies another one in the following cycle.
`define TEDT_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/tedt_pkg.sv @@
// Shared types and constants of the triangle edge table.
package tedt_pkg;

    localparam int MAX_EDGES = 4096;
    localparam int IDX_W     = $clog2(MAX_EDGES);
    localparam int CNT_W     = IDX_W + 1;
    localparam int POINT_W   = 16;
    localparam int ENTRY_W   = 2 * POINT_W;
    localparam int CMD_W     = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_ADD   = 2'd0,
        CMD_CLEAR = 2'd1,
        CMD_READ  = 2'd2
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_APPEND,
        ST_READ,
        ST_READ_DATA,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic               rd_en;
        logic [IDX_W-1:0]   rd_addr;
        logic               wr_en;
        logic [IDX_W-1:0]   wr_addr;
        logic [ENTRY_W-1:0] wr_data;
    } mem_req_t;

    typedef struct packed {
        logic [IDX_W-1:0]   edge_ab;
        logic [IDX_W-1:0]   edge_bc;
        logic [IDX_W-1:0]   edge_ca;
        logic [CNT_W-1:0]   edge_total;
        logic               table_full;
        logic [POINT_W-1:0] entry_start;
        logic [POINT_W-1:0] entry_end;
    } res_t;

endpackage

@@ hdl/tedt_edge_ram.sv @@
// Simple dual-port synchronous RAM with one write port and a registered read port.
module tedt_edge_ram #(
    parameter int DATA_W = 32,
    parameter int ADDR_W = 12
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [2**ADDR_W];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ hdl/tedt_ctrl.sv @@
// Sequencer that scans, appends, clears and reads the edge table.
module tedt_ctrl (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [tedt_pkg::CMD_W-1:0]        in_command,
    input  logic [tedt_pkg::POINT_W-1:0]      in_point_a,
    input  logic [tedt_pkg::POINT_W-1:0]      in_point_b,
    input  logic [tedt_pkg::POINT_W-1:0]      in_point_c,
    input  logic [tedt_pkg::IDX_W-1:0]        in_read_index,
    output tedt_pkg::mem_req_t                mem_req,
    input  logic [tedt_pkg::ENTRY_W-1:0]      mem_rd_data,
    output logic                              res_valid,
    input  logic                              res_ready,
    output tedt_pkg::res_t                    res
);

    localparam logic [tedt_pkg::CNT_W-1:0] COUNT_MAX = tedt_pkg::CNT_W'(tedt_pkg::MAX_EDGES);

    tedt_pkg::state_t state_reg, state_next;

    logic [tedt_pkg::POINT_W-1:0] a_reg, a_next;
    logic [tedt_pkg::POINT_W-1:0] b_reg, b_next;
    logic [tedt_pkg::POINT_W-1:0] c_reg, c_next;
    logic [tedt_pkg::IDX_W-1:0]   ridx_reg, ridx_next;
    logic [tedt_pkg::CNT_W-1:0]   count_reg, count_next;
    logic [tedt_pkg::CNT_W-1:0]   scan_ptr_reg, scan_ptr_next;
    logic                         cmp_valid_reg, cmp_valid_next;
    logic [tedt_pkg::IDX_W-1:0]   cmp_idx_reg, cmp_idx_next;
    logic [2:0]                   found_reg, found_next;
    logic [2:0][tedt_pkg::IDX_W-1:0] slot_reg, slot_next;
    logic                         full_reg, full_next;
    logic [1:0]                   step_reg, step_next;
    logic                         rd_ok_reg, rd_ok_next;
    logic [tedt_pkg::POINT_W-1:0] rs_reg, rs_next;
    logic [tedt_pkg::POINT_W-1:0] re_reg, re_next;

    logic [2:0]                      found_upd;
    logic [2:0][tedt_pkg::IDX_W-1:0] slot_upd;
    logic                            scan_issue;
    logic [tedt_pkg::POINT_W-1:0]    rd_start, rd_end;
    logic                            accept;

    assign rd_start = mem_rd_data[tedt_pkg::ENTRY_W-1:tedt_pkg::POINT_W];
    assign rd_end   = mem_rd_data[tedt_pkg::POINT_W-1:0];
    assign accept   = in_valid && in_ready;

    // Compare the entry read last cycle; later tests in one entry override earlier ones.
    always_comb begin
        found_upd = found_reg;
        slot_upd  = slot_reg;
        if (cmp_valid_reg) begin
            if (rd_start == a_reg) begin
                if (rd_end == b_reg) begin
                    slot_upd[0] = cmp_idx_reg;
                    found_upd[0] = 1'b1;
                end else if (rd_end == c_reg) begin
                    slot_upd[2] = cmp_idx_reg;
                    found_upd[2] = 1'b1;
                end
            end
            if (rd_start == b_reg) begin
                if (rd_end == a_reg) begin
                    slot_upd[0] = cmp_idx_reg;
                    found_upd[0] = 1'b1;
                end else if (rd_end == c_reg) begin
                    slot_upd[1] = cmp_idx_reg;
                    found_upd[1] = 1'b1;
                end
            end
            if (rd_start == c_reg) begin
                if (rd_end == b_reg) begin
                    slot_upd[1] = cmp_idx_reg;
                    found_upd[1] = 1'b1;
                end else if (rd_end == a_reg) begin
                    slot_upd[2] = cmp_idx_reg;
                    found_upd[2] = 1'b1;
                end
            end
        end
        scan_issue = (scan_ptr_reg < count_reg) && !(&found_upd);
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            tedt_pkg::ST_IDLE: begin
                if (accept) begin
                    case (in_command)
                        tedt_pkg::CMD_ADD:  state_next = tedt_pkg::ST_SCAN;
                        tedt_pkg::CMD_READ: state_next = tedt_pkg::ST_READ;
                        default:            state_next = tedt_pkg::ST_DONE;
                    endcase
                end
            end
            tedt_pkg::ST_SCAN: begin
                if (!scan_issue) begin
                    state_next = tedt_pkg::ST_APPEND;
                end
            end
            tedt_pkg::ST_APPEND: begin
                if (step_reg == 2'd2) begin
                    state_next = tedt_pkg::ST_DONE;
                end
            end
            tedt_pkg::ST_READ:      state_next = tedt_pkg::ST_READ_DATA;
            tedt_pkg::ST_READ_DATA: state_next = tedt_pkg::ST_DONE;
            tedt_pkg::ST_DONE: begin
                if (res_ready) begin
                    state_next = tedt_pkg::ST_IDLE;
                end
            end
            default: state_next = tedt_pkg::ST_IDLE;
        endcase
    end

    // Datapath and outputs.
    always_comb begin
        a_next         = a_reg;
        b_next         = b_reg;
        c_next         = c_reg;
        ridx_next      = ridx_reg;
        count_next     = count_reg;
        scan_ptr_next  = scan_ptr_reg;
        cmp_valid_next = 1'b0;
        cmp_idx_next   = cmp_idx_reg;
        found_next     = found_reg;
        slot_next      = slot_reg;
        full_next      = full_reg;
        step_next      = step_reg;
        rd_ok_next     = rd_ok_reg;
        rs_next        = rs_reg;
        re_next        = re_reg;
        mem_req        = '0;
        in_ready       = 1'b0;
        res_valid      = 1'b0;

        case (state_reg)
            tedt_pkg::ST_IDLE: begin
                in_ready = 1'b1;
                if (accept) begin
                    a_next        = in_point_a;
                    b_next        = in_point_b;
                    c_next        = in_point_c;
                    ridx_next     = in_read_index;
                    scan_ptr_next = '0;
                    found_next    = '0;
                    slot_next     = '0;
                    full_next     = 1'b0;
                    step_next     = '0;
                    rs_next       = '0;
                    re_next       = '0;
                    if (in_command == tedt_pkg::CMD_CLEAR) begin
                        count_next = '0;
                    end
                end
            end
            tedt_pkg::ST_SCAN: begin
                found_next = found_upd;
                slot_next  = slot_upd;
                if (scan_issue) begin
                    mem_req.rd_en  = 1'b1;
                    mem_req.rd_addr = scan_ptr_reg[tedt_pkg::IDX_W-1:0];
                    cmp_valid_next = 1'b1;
                    cmp_idx_next   = scan_ptr_reg[tedt_pkg::IDX_W-1:0];
                    scan_ptr_next  = scan_ptr_reg + 1'b1;
                end
            end
            tedt_pkg::ST_APPEND: begin
                step_next = step_reg + 1'b1;
                if (!found_reg[step_reg]) begin
                    if (count_reg < COUNT_MAX) begin
                        mem_req.wr_en   = 1'b1;
                        mem_req.wr_addr = count_reg[tedt_pkg::IDX_W-1:0];
                        case (step_reg)
                            2'd0:    mem_req.wr_data = {a_reg, b_reg};
                            2'd1:    mem_req.wr_data = {b_reg, c_reg};
                            default: mem_req.wr_data = {c_reg, a_reg};
                        endcase
                        slot_next[step_reg] = count_reg[tedt_pkg::IDX_W-1:0];
                        count_next = count_reg + 1'b1;
                    end else begin
                        full_next = 1'b1;
                    end
                end
            end
            tedt_pkg::ST_READ: begin
                rd_ok_next      = {1'b0, ridx_reg} < count_reg;
                mem_req.rd_en   = 1'b1;
                mem_req.rd_addr = ridx_reg;
            end
            tedt_pkg::ST_READ_DATA: begin
                if (rd_ok_reg) begin
                    rs_next = rd_start;
                    re_next = rd_end;
                end
            end
            tedt_pkg::ST_DONE: begin
                res_valid = 1'b1;
            end
            default: begin
            end
        endcase

        res.edge_ab     = slot_reg[0];
        res.edge_bc     = slot_reg[1];
        res.edge_ca     = slot_reg[2];
        res.edge_total  = count_reg;
        res.table_full  = full_reg;
        res.entry_start = rs_reg;
        res.entry_end   = re_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= tedt_pkg::ST_IDLE;
            count_reg     <= '0;
            cmp_valid_reg <= 1'b0;
            step_reg      <= '0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            cmp_valid_reg <= cmp_valid_next;
            step_reg      <= step_next;
        end
    end

    always_ff @(posedge aclk) begin
        a_reg        <= a_next;
        b_reg        <= b_next;
        c_reg        <= c_next;
        ridx_reg     <= ridx_next;
        scan_ptr_reg <= scan_ptr_next;
        cmp_idx_reg  <= cmp_idx_next;
        found_reg    <= found_next;
        slot_reg     <= slot_next;
        full_reg     <= full_next;
        rd_ok_reg    <= rd_ok_next;
        rs_reg       <= rs_next;
        re_reg       <= re_next;
    end

endmodule

@@ hdl/triangle_edge_dedup_table.sv @@
// Throughput: one item at a time; the scan reads one stored edge per cycle through the
// single read port of the edge memory, and the append phase takes one step per edge.
// Reset: aresetn (synchronous, active low) clears the edge count, the sequencer and the
// output beat; edge memory contents are left as they are, since only entries below the
// count are ever used.
`include "triangle_edge_dedup_table_defines.svh"

module triangle_edge_dedup_table (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [tedt_pkg::CMD_W-1:0]    s_command,
    input  logic [tedt_pkg::POINT_W-1:0]  s_point_a,
    input  logic [tedt_pkg::POINT_W-1:0]  s_point_b,
    input  logic [tedt_pkg::POINT_W-1:0]  s_point_c,
    input  logic [tedt_pkg::IDX_W-1:0]    s_read_index,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [tedt_pkg::IDX_W-1:0]    m_edge_ab,
    output logic [tedt_pkg::IDX_W-1:0]    m_edge_bc,
    output logic [tedt_pkg::IDX_W-1:0]    m_edge_ca,
    output logic [tedt_pkg::CNT_W-1:0]    m_edge_total,
    output logic                          m_table_full,
    output logic [tedt_pkg::POINT_W-1:0]  m_entry_start,
    output logic [tedt_pkg::POINT_W-1:0]  m_entry_end
);

    tedt_pkg::mem_req_t               mem_req;
    logic [tedt_pkg::ENTRY_W-1:0]     mem_rd_data;
    logic                             res_valid;
    logic                             res_ready;
    tedt_pkg::res_t                   res;

    // The output beat lives in its own register, so the sequencer goes back to idle
    // and takes the next input beat while a finished result still waits for m_ready.
    logic            m_valid_reg, m_valid_next;
    tedt_pkg::res_t  m_res_reg, m_res_next;

    // Each memory word holds one directed edge: start point in the upper half,
    // end point in the lower half.
    tedt_edge_ram #(
        .DATA_W (tedt_pkg::ENTRY_W),
        .ADDR_W (tedt_pkg::IDX_W)
    ) u_edge_ram (
        .aclk    (aclk),
        .wr_en   (mem_req.wr_en),
        .wr_addr (mem_req.wr_addr),
        .wr_data (mem_req.wr_data),
        .rd_en   (mem_req.rd_en),
        .rd_addr (mem_req.rd_addr),
        .rd_data (mem_rd_data)
    );

    // The sequencer scans the table from entry zero, one entry per cycle, stops early
    // once every edge of the triangle is found, then appends the missing ones in order.
    tedt_ctrl u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .in_valid      (s_valid),
        .in_ready      (s_ready),
        .in_command    (s_command),
        .in_point_a    (s_point_a),
        .in_point_b    (s_point_b),
        .in_point_c    (s_point_c),
        .in_read_index (s_read_index),
        .mem_req       (mem_req),
        .mem_rd_data   (mem_rd_data),
        .res_valid     (res_valid),
        .res_ready     (res_ready),
        .res           (res)
    );

    // The output register can take a new result when it is empty or being drained.
    assign res_ready = !m_valid_reg || m_ready;

    always_comb begin
        m_valid_next = m_valid_reg;
        m_res_next   = m_res_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (res_valid && res_ready) begin
            m_valid_next = 1'b1;
            m_res_next   = res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_res_reg <= m_res_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_edge_ab     = m_res_reg.edge_ab;
    assign m_edge_bc     = m_res_reg.edge_bc;
    assign m_edge_ca     = m_res_reg.edge_ca;
    assign m_edge_total  = m_res_reg.edge_total;
    assign m_table_full  = m_res_reg.table_full;
    assign m_entry_start = m_res_reg.entry_start;
    assign m_entry_end   = m_res_reg.entry_end;

    // The sequencer never offers a result while it is ready for a new beat.
    `TEDT_ASSERT_ALWAYS(a_ready_excl_result, aclk, aresetn, !(s_ready && res_valid), "sequencer ready while holding a result")

    // A full table can only be reported when the count sits at the table size.
    `TEDT_ASSERT_IMPLIES(a_full_at_max, aclk, aresetn, m_valid && m_table_full, m_edge_total == tedt_pkg::CNT_W'(tedt_pkg::MAX_EDGES), "table_full with count below capacity")

    // The count never exceeds the table size.
    `TEDT_ASSERT_ALWAYS(a_count_bound, aclk, aresetn, res.edge_total <= tedt_pkg::CNT_W'(tedt_pkg::MAX_EDGES), "edge count beyond capacity")

    // A clear beat empties the table right away.
    `TEDT_ASSERT_NEXT(a_clear_empties, aclk, aresetn, s_valid && s_ready && (s_command == tedt_pkg::CMD_CLEAR), res.edge_total == '0, "clear did not reset the edge count")

endmodule

@@ test/tb_triangle_edge_dedup_table.sv @@
// Self-checking testbench for the triangle edge deduplication table.
`timescale 1ns / 1ps

module tb_triangle_edge_dedup_table;

    localparam int CLK_PERIOD       = 4;
    localparam int RESET_CYCLES     = 9;
    // Command code 3 is unused by the block and must leave the table alone.
    localparam logic [tedt_pkg::CMD_W-1:0] CMD_NOP = 2'd3;
    localparam int RANDOM_PER_PHASE = 30;
    localparam int NUM_PHASES       = 4;
    // An add scans the table, so the final quiet period covers a full scan.
    localparam int DRAIN_CYCLES     = tedt_pkg::MAX_EDGES + 50;

    // One directed stimulus row. Where "typed" is set, "want" holds the result
    // written out by hand; otherwise the result comes from the predictor.
    typedef struct {
        logic [tedt_pkg::CMD_W-1:0]   cmd;
        logic [tedt_pkg::POINT_W-1:0] a;
        logic [tedt_pkg::POINT_W-1:0] b;
        logic [tedt_pkg::POINT_W-1:0] c;
        logic [tedt_pkg::IDX_W-1:0]   idx;
        bit                           typed;
        tedt_pkg::res_t               want;
    } stim_row_t;

    localparam tedt_pkg::res_t NO_TYPED_RESULT = '0;

    logic                         aclk          = 1'b0;
    logic                         aresetn       = 1'b0;
    logic                         s_valid       = 1'b0;
    logic                         s_ready;
    logic [tedt_pkg::CMD_W-1:0]   s_command     = tedt_pkg::CMD_ADD;
    logic [tedt_pkg::POINT_W-1:0] s_point_a     = '0;
    logic [tedt_pkg::POINT_W-1:0] s_point_b     = '0;
    logic [tedt_pkg::POINT_W-1:0] s_point_c     = '0;
    logic [tedt_pkg::IDX_W-1:0]   s_read_index  = '0;
    logic                         m_valid;
    logic                         m_ready       = 1'b0;
    logic [tedt_pkg::IDX_W-1:0]   m_edge_ab;
    logic [tedt_pkg::IDX_W-1:0]   m_edge_bc;
    logic [tedt_pkg::IDX_W-1:0]   m_edge_ca;
    logic [tedt_pkg::CNT_W-1:0]   m_edge_total;
    logic                         m_table_full;
    logic [tedt_pkg::POINT_W-1:0] m_entry_start;
    logic [tedt_pkg::POINT_W-1:0] m_entry_end;

    // Our own copy of the edge table, kept in step with every accepted beat.
    logic [tedt_pkg::POINT_W-1:0] shadow_start [tedt_pkg::MAX_EDGES];
    logic [tedt_pkg::POINT_W-1:0] shadow_end   [tedt_pkg::MAX_EDGES];
    int unsigned                  shadow_count = 0;

    // Results the block still owes us, oldest first.
    tedt_pkg::res_t pending_results [$];
    int             mismatches = 0;

    // Idle chances in percent, per phase of the random part.
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int send_idle_by_phase  [NUM_PHASES] = '{0, 87, 0, 37};
    int recv_stall_by_phase [NUM_PHASES] = '{0, 0, 87, 37};

    // Directed rows: reset state, a reversed triangle that finds each of its
    // edges (the c-a match lands in the ca slot), reads in and out of range,
    // the unused command, triangles with repeated points, clear and reuse.
    stim_row_t directed_rows [20] = '{
        '{tedt_pkg::CMD_READ, 16'd0, 16'd0, 16'd0, 12'd0, 1'b1,
          '{12'd0, 12'd0, 12'd0, 13'd0, 1'b0, 16'd0, 16'd0}},
        '{tedt_pkg::CMD_ADD, 16'd1, 16'd2, 16'd3, 12'd0, 1'b1,
          '{12'd0, 12'd1, 12'd2, 13'd3, 1'b0, 16'd0, 16'd0}},
        '{tedt_pkg::CMD_ADD, 16'd2, 16'd1, 16'd3, 12'd0, 1'b1,
          '{12'd0, 12'd2, 12'd1, 13'd3, 1'b0, 16'd0, 16'd0}},
        '{tedt_pkg::CMD_READ, 16'd0, 16'd0, 16'd0, 12'd2, 1'b1,
          '{12'd0, 12'd0, 12'd0, 13'd3, 1'b0, 16'd3, 16'd1}},
        '{tedt_pkg::CMD_READ, 16'd0, 16'd0, 16'd0, 12'd3, 1'b1,
          '{12'd0, 12'd0, 12'd0, 13'd3, 1'b0, 16'd0, 16'd0}},
        '{CMD_NOP, 16'hFFFF, 16'hFFFF, 16'hFFFF, 12'hFFF, 1'b1,
          '{12'd0, 12'd0, 12'd0, 13'd3, 1'b0, 16'd0, 16'd0}},
        '{tedt_pkg::CMD_ADD, 16'd3, 16'd1, 16'd4, 12'd0, 1'b0, NO_TYPED_RESULT},
        '{tedt_pkg::CMD_ADD, 16'hFFFF, 16'd0, 16'hFFFF, 12'd0, 1'b0, NO_TYPED_RESULT},
        '{tedt_pkg::CMD_ADD, 16'd0, 16'd0, 16'd0, 12'd0, 1'b0, NO_TYPED_RESULT},
        '{tedt_pkg::CMD_ADD, 16'd0, 16'd0, 16'd0, 12'd0, 1'b0, NO_TYPED_RESULT},
        '{tedt_pkg::CMD_ADD, 16'hFFFF, 16'hFFFF, 16'hFFFF, 12'd0, 1'b0, NO_TYPED_RESULT},
        '{tedt_pkg::CMD_ADD, 16'd1, 16'd2, 16'd1, 12'd0, 1'b0, NO_TYPED_RESULT},
        '{tedt_pkg::CMD_READ, 16'd0, 16'd0, 16'd0, 12'hFFF, 1'b0, NO_TYPED_RESULT},
        '{tedt_pkg::CMD_READ, 16'd0, 16'd0, 16'd0, 12'd0, 1'b0, NO_TYPED_RESULT},
        '{tedt_pkg::CMD_CLEAR, 16'h5A5A, 16'hA5A5, 16'h0F0F, 12'hAAA, 1'b1,
          '{12'd0, 12'd0, 12'd0, 13'd0, 1'b0, 16'd0, 16'd0}},
        '{tedt_pkg::CMD_READ, 16'd0, 16'd0, 16'd0, 12'd0, 1'b1,
          '{12'd0, 12'd0, 12'd0, 13'd0, 1'b0, 16'd0, 16'd0}},
        '{tedt_pkg::CMD_ADD, 16'hAAAA, 16'h5555, 16'h1234, 12'd0, 1'b1,
          '{12'd0, 12'd1, 12'd2, 13'd3, 1'b0, 16'd0, 16'd0}},
        '{tedt_pkg::CMD_ADD, 16'h1234, 16'hAAAA, 16'h5555, 12'd0, 1'b0, NO_TYPED_RESULT},
        '{tedt_pkg::CMD_READ, 16'd0, 16'd0, 16'd0, 12'd1, 1'b0, NO_TYPED_RESULT},
        '{tedt_pkg::CMD_CLEAR, 16'd0, 16'd0, 16'd0, 12'd0, 1'b1,
          '{12'd0, 12'd0, 12'd0, 13'd0, 1'b0, 16'd0, 16'd0}}
    };

    triangle_edge_dedup_table u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_command     (s_command),
        .s_point_a     (s_point_a),
        .s_point_b     (s_point_b),
        .s_point_c     (s_point_c),
        .s_read_index  (s_read_index),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_edge_ab     (m_edge_ab),
        .m_edge_bc     (m_edge_bc),
        .m_edge_ca     (m_edge_ca),
        .m_edge_total  (m_edge_total),
        .m_table_full  (m_table_full),
        .m_entry_start (m_entry_start),
        .m_entry_end   (m_entry_end)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // Applies one beat to the shadow table and returns the result it must
    // produce. An add looks up each edge in either direction, stops scanning
    // once all three are known, and appends the missing ones in ab, bc, ca
    // order; an append that finds the table full leaves its index at zero.
    function automatic tedt_pkg::res_t lookup_triangle_edges(
            input logic [tedt_pkg::CMD_W-1:0] cmd,
            input logic [tedt_pkg::POINT_W-1:0] a,
            input logic [tedt_pkg::POINT_W-1:0] b,
            input logic [tedt_pkg::POINT_W-1:0] c,
            input logic [tedt_pkg::IDX_W-1:0] idx);
        tedt_pkg::res_t               r;
        logic [tedt_pkg::POINT_W-1:0] from_pt [3];
        logic [tedt_pkg::POINT_W-1:0] to_pt   [3];
        int unsigned                  slot    [3];
        bit                           found   [3];
        r          = '0;
        from_pt[0] = a;
        from_pt[1] = b;
        from_pt[2] = c;
        to_pt[0]   = b;
        to_pt[1]   = c;
        to_pt[2]   = a;
        for (int k = 0; k < 3; k++) begin
            slot[k]  = 0;
            found[k] = 1'b0;
        end
        case (cmd)
            tedt_pkg::CMD_ADD: begin
                for (int unsigned j = 0;
                     j < shadow_count && !(found[0] && found[1] && found[2]); j++) begin
                    // Tests within one entry are not exclusive: with repeated
                    // points a later test overrides an earlier one.
                    if (shadow_start[j] == a) begin
                        if (shadow_end[j] == b) begin
                            slot[0] = j;
                            found[0] = 1'b1;
                        end else if (shadow_end[j] == c) begin
                            slot[2] = j;
                            found[2] = 1'b1;
                        end
                    end
                    if (shadow_start[j] == b) begin
                        if (shadow_end[j] == a) begin
                            slot[0] = j;
                            found[0] = 1'b1;
                        end else if (shadow_end[j] == c) begin
                            slot[1] = j;
                            found[1] = 1'b1;
                        end
                    end
                    if (shadow_start[j] == c) begin
                        if (shadow_end[j] == b) begin
                            slot[1] = j;
                            found[1] = 1'b1;
                        end else if (shadow_end[j] == a) begin
                            slot[2] = j;
                            found[2] = 1'b1;
                        end
                    end
                end
                for (int k = 0; k < 3; k++) begin
                    if (!found[k]) begin
                        if (shadow_count < tedt_pkg::MAX_EDGES) begin
                            shadow_start[shadow_count] = from_pt[k];
                            shadow_end[shadow_count]   = to_pt[k];
                            slot[k] = shadow_count;
                            shadow_count++;
                        end else begin
                            r.table_full = 1'b1;
                        end
                    end
                end
                r.edge_ab = tedt_pkg::IDX_W'(slot[0]);
                r.edge_bc = tedt_pkg::IDX_W'(slot[1]);
                r.edge_ca = tedt_pkg::IDX_W'(slot[2]);
            end
            tedt_pkg::CMD_CLEAR: begin
                shadow_count = 0;
            end
            tedt_pkg::CMD_READ: begin
                if (idx < shadow_count) begin
                    r.entry_start = shadow_start[idx];
                    r.entry_end   = shadow_end[idx];
                end
            end
            default: begin
            end
        endcase
        r.edge_total = tedt_pkg::CNT_W'(shadow_count);
        return r;
    endfunction

    // Drives one beat at the falling edge, after a random number of idle
    // cycles, and holds it until the block takes it at a rising edge.
    // Valid stays high straight into the next beat when no idle is drawn.
    task automatic send_beat(input logic [tedt_pkg::CMD_W-1:0] cmd,
                             input logic [tedt_pkg::POINT_W-1:0] a,
                             input logic [tedt_pkg::POINT_W-1:0] b,
                             input logic [tedt_pkg::POINT_W-1:0] c,
                             input logic [tedt_pkg::IDX_W-1:0] idx, input bit typed,
                             input tedt_pkg::res_t want);
        tedt_pkg::res_t predicted;
        @(negedge aclk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_command    = cmd;
        s_point_a    = a;
        s_point_b    = b;
        s_point_c    = c;
        s_read_index = idx;
        s_valid      = 1'b1;
        do @(posedge aclk); while (!s_ready);
        // The shadow table follows every beat, typed rows included.
        predicted = lookup_triangle_edges(cmd, a, b, c, idx);
        pending_results.push_back(typed ? want : predicted);
    endtask

    // Most points come from a tiny pool so edges recur and get matched;
    // a few are the field extremes.
    function automatic logic [tedt_pkg::POINT_W-1:0] pick_point(input bit wide);
        if (wide) begin
            return tedt_pkg::POINT_W'($urandom);
        end
        case ($urandom_range(9))
            0: return '1;
            1: return '0;
            default: return tedt_pkg::POINT_W'($urandom_range(5));
        endcase
    endfunction

    // One random beat: mostly adds over the small point pool, then reads
    // (largely of stored entries), clears, wide adds and the unused command.
    task automatic send_random_beat();
        int unsigned                roll;
        bit                         wide;
        logic [tedt_pkg::CMD_W-1:0] cmd;
        logic [tedt_pkg::IDX_W-1:0] idx;
        roll = $urandom_range(99);
        wide = (roll >= 60);
        if (roll < 70) begin
            cmd = tedt_pkg::CMD_ADD;
        end else if (roll < 88) begin
            cmd = tedt_pkg::CMD_READ;
        end else if (roll < 94) begin
            cmd = tedt_pkg::CMD_CLEAR;
        end else begin
            cmd = CMD_NOP;
        end
        if (shadow_count != 0 && $urandom_range(3) != 0) begin
            idx = tedt_pkg::IDX_W'($urandom_range(shadow_count - 1));
        end else begin
            idx = tedt_pkg::IDX_W'($urandom);
        end
        send_beat(cmd, pick_point(wide), pick_point(wide), pick_point(wide), idx, 1'b0,
                  NO_TYPED_RESULT);
    endtask

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (got !== want) begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    // The receiver stalls at random; the chance is set per phase.
    always @(negedge aclk) begin
        m_ready = ($urandom_range(99) >= recv_stall_pct);
    end

    // Every result beat is checked field by field against the oldest
    // outstanding expectation.
    always @(posedge aclk) begin
        tedt_pkg::res_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t ns: result beat with nothing expected, edge_total %0d",
                         $time, m_edge_total);
                mismatches++;
            end else begin
                want = pending_results.pop_front();
                compare_field("edge_ab", 32'(want.edge_ab), 32'(m_edge_ab));
                compare_field("edge_bc", 32'(want.edge_bc), 32'(m_edge_bc));
                compare_field("edge_ca", 32'(want.edge_ca), 32'(m_edge_ca));
                compare_field("edge_total", 32'(want.edge_total), 32'(m_edge_total));
                compare_field("table_full", 32'(want.table_full), 32'(m_table_full));
                compare_field("entry_start", 32'(want.entry_start), 32'(m_entry_start));
                compare_field("entry_end", 32'(want.entry_end), 32'(m_entry_end));
            end
        end
    end

    initial begin
        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed rows, with no idling on either side.
        foreach (directed_rows[i]) begin
            send_beat(directed_rows[i].cmd, directed_rows[i].a, directed_rows[i].b,
                      directed_rows[i].c, directed_rows[i].idx, directed_rows[i].typed,
                      directed_rows[i].want);
        end

        // Random part, one phase per idling pattern.
        for (int p = 0; p < NUM_PHASES; p++) begin
            send_idle_pct  = send_idle_by_phase[p];
            recv_stall_pct = recv_stall_by_phase[p];
            repeat (RANDOM_PER_PHASE) send_random_beat();
        end

        @(negedge aclk);
        s_valid = 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        // Stay a little longer to catch any stray result beat.
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // Watchdog: a correct run finishes well before this timeout, even with every add
    // scanning a full table under the longest stalls.
    initial begin
        #(80_000_000);
        $display("FAIL");
        $finish;
    end

endmodule
